FILE: rtl/core/bzcv_pkg.sv
package bzcv_pkg;

  // Zone geometry
  localparam int unsigned ZONE_BYTES = 2576;
  localparam int unsigned POS_W      = 12;
  localparam int unsigned HDR_BYTES  = 4;

  // Running sum reduction
  localparam logic [16:0] ADLER_MOD = 17'd65521;

  // Register defaults
  localparam logic [31:0] MAGIC_DEFAULT = 32'h5A4D_5348;

  // Configuration port geometry
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_EXPECTED_MAGIC = 2'd0,
    CFG_FORCE_BYPASS   = 2'd1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_BAD_MAGIC = 2'd1,
    STATUS_BAD_SUM   = 2'd2,
    STATUS_SHORT     = 2'd3
  } status_e;

endpackage

FILE: rtl/core/bzcv_in_if.sv
interface bzcv_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] zone_byte;
  logic       frame_last;

  modport source (output valid, output zone_byte, output frame_last, input ready);
  modport sink   (input valid, input zone_byte, input frame_last, output ready);
endinterface

FILE: rtl/core/bzcv_out_if.sv
interface bzcv_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic [31:0] stored_sum;
  logic [31:0] computed_sum;
  logic [31:0] magic_seen;

  modport source (output valid, output status, output stored_sum, output computed_sum,
                  output magic_seen, input ready);
  modport sink   (input valid, input status, input stored_sum, input computed_sum,
                  input magic_seen, output ready);
endinterface

FILE: rtl/core/boot_zone_checksum_validator_top.sv
// Boot zone checksum validator: takes a zone image one byte per item (bytes 0-3 the
// stored checksum, bytes 4-7 the magic, little-endian) and runs an Adler-style pair of
// sums, both starting at zero, over byte 4 up to the end of the zone (ZONE_BYTES);
// bytes past the zone are dropped. The item flagged frame_last yields one result with
// status, stored checksum, computed checksum and magic, and clears the frame state.
// An item is taken every cycle unless a waiting result stalls the last byte of the next
// frame (input register, sum update and status decision, result register); a byte
// reaches the sum stage in the cycle after it is accepted, and a result is registered as
// its last byte leaves the input register. The user writes configuration (expected magic,
// force bypass) via cfg_we_i/cfg_index_i/cfg_data_i only while idle; block does not enforce it.
module boot_zone_checksum_validator_top (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [bzcv_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [bzcv_pkg::CFG_DATA_W-1:0] cfg_data_i,
  bzcv_in_if.sink                         in_i,
  bzcv_out_if.source                      out_o
);

  // Configuration registers
  logic [31:0] exp_magic_q;
  logic        force_q;

  // Input register
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_last_q;

  // Frame state
  logic [bzcv_pkg::POS_W-1:0] pos_q, pos_d;
  logic [15:0] sum_low_q, sum_low_d;
  logic [15:0] sum_high_q, sum_high_d;
  logic [31:0] chk_q, chk_d;
  logic [31:0] magic_q, magic_d;

  // Result register
  logic                 out_valid_q;
  bzcv_pkg::status_e    out_status_q, status_d;
  logic [31:0]          out_stored_q;
  logic [31:0]          out_computed_q;
  logic [31:0]          out_magic_q;

  logic        advance;
  logic        take;
  logic        in_zone;
  logic [16:0] t_low;
  logic [16:0] t_high;
  logic [31:0] computed_d;

  // Write configuration; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      exp_magic_q <= bzcv_pkg::MAGIC_DEFAULT;
      force_q     <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        bzcv_pkg::CFG_EXPECTED_MAGIC: exp_magic_q <= cfg_data_i[31:0];
        bzcv_pkg::CFG_FORCE_BYPASS:   force_q     <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // A held item moves on unless it is a last byte facing a full result register
  assign advance  = !in_last_q || !out_valid_q || out_o.ready;
  assign take     = in_valid_q && advance;
  assign in_i.ready = !in_valid_q || advance;

  // Capture input item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_i.ready) begin
      in_valid_q <= in_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      in_byte_q <= in_i.zone_byte;
      in_last_q <= in_i.frame_last;
    end
  end

  // Update sums and header words for the held byte
  always_comb begin
    pos_d      = pos_q;
    sum_low_d  = sum_low_q;
    sum_high_d = sum_high_q;
    chk_d      = chk_q;
    magic_d    = magic_q;
    in_zone    = pos_q < bzcv_pkg::POS_W'(bzcv_pkg::ZONE_BYTES);

    t_low = {1'b0, sum_low_q} + {9'd0, in_byte_q};
    if (t_low >= bzcv_pkg::ADLER_MOD) begin
      t_low = t_low - bzcv_pkg::ADLER_MOD;
    end
    t_high = {1'b0, sum_high_q} + t_low;
    if (t_high >= bzcv_pkg::ADLER_MOD) begin
      t_high = t_high - bzcv_pkg::ADLER_MOD;
    end

    if (in_zone) begin
      pos_d = pos_q + 1'b1;
      if (pos_q < bzcv_pkg::POS_W'(bzcv_pkg::HDR_BYTES)) begin
        case (pos_q[1:0])
          2'd0:    chk_d[7:0]   = in_byte_q;
          2'd1:    chk_d[15:8]  = in_byte_q;
          2'd2:    chk_d[23:16] = in_byte_q;
          default: chk_d[31:24] = in_byte_q;
        endcase
      end else begin
        if (pos_q < bzcv_pkg::POS_W'(2 * bzcv_pkg::HDR_BYTES)) begin
          case (pos_q[1:0])
            2'd0:    magic_d[7:0]   = in_byte_q;
            2'd1:    magic_d[15:8]  = in_byte_q;
            2'd2:    magic_d[23:16] = in_byte_q;
            default: magic_d[31:24] = in_byte_q;
          endcase
        end
        sum_low_d  = t_low[15:0];
        sum_high_d = t_high[15:0];
      end
    end

    // Decide status in check order: short, magic, checksum
    computed_d = {sum_high_d, sum_low_d};
    if (pos_d < bzcv_pkg::POS_W'(bzcv_pkg::ZONE_BYTES)) begin
      status_d = bzcv_pkg::STATUS_SHORT;
    end else if ((magic_d != exp_magic_q) && !force_q) begin
      status_d = bzcv_pkg::STATUS_BAD_MAGIC;
    end else if (chk_d != computed_d) begin
      status_d = bzcv_pkg::STATUS_BAD_SUM;
    end else begin
      status_d = bzcv_pkg::STATUS_OK;
    end
  end

  // Advance frame state; clear it after the last byte
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q      <= '0;
      sum_low_q  <= '0;
      sum_high_q <= '0;
      chk_q      <= '0;
      magic_q    <= '0;
    end else if (take) begin
      if (in_last_q) begin
        pos_q      <= '0;
        sum_low_q  <= '0;
        sum_high_q <= '0;
        chk_q      <= '0;
        magic_q    <= '0;
      end else begin
        pos_q      <= pos_d;
        sum_low_q  <= sum_low_d;
        sum_high_q <= sum_high_d;
        chk_q      <= chk_d;
        magic_q    <= magic_d;
      end
    end
  end

  // Load result on the last byte, drop it once taken
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (take && in_last_q) begin
      out_valid_q <= 1'b1;
    end else if (out_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take && in_last_q) begin
      out_status_q   <= status_d;
      out_stored_q   <= chk_d;
      out_computed_q <= computed_d;
      out_magic_q    <= magic_d;
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.status       = out_status_q;
  assign out_o.stored_sum   = out_stored_q;
  assign out_o.computed_sum = out_computed_q;
  assign out_o.magic_seen   = out_magic_q;

  // Position never runs past the zone
  a_pos_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pos_q <= bzcv_pkg::POS_W'(bzcv_pkg::ZONE_BYTES))
    else $error("byte position beyond zone size");

  // Both sums stay reduced
  a_sum_reduced: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ({1'b0, sum_low_q} < bzcv_pkg::ADLER_MOD) && ({1'b0, sum_high_q} < bzcv_pkg::ADLER_MOD))
    else $error("running sum not reduced");

  // A last byte leaves a result pending and a cleared frame
  a_last_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    take && in_last_q |=> out_valid_q && (pos_q == '0) && (sum_low_q == '0))
    else $error("frame end did not load result or clear state");

  // A held item stalls only behind a waiting result
  a_stall_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && !advance |-> out_valid_q && !out_o.ready && in_last_q)
    else $error("input stalled without a waiting result");

endmodule
